/* hw/rtl/selective_repeat_retransmit_picker_top_assert.svh */
// Assertion macros shared by the retransmit picker RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SELECTIVE_REPEAT_RETRANSMIT_PICKER_TOP_ASSERT_SVH
`define SELECTIVE_REPEAT_RETRANSMIT_PICKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRRP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srrp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRRP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srrp assertion failed");

`endif

/* hw/rtl/srrp_pkg.sv */
// Types and constants of the selective-repeat retransmit picker.
// Depends on nothing; used by srrp_table and the top level.
package srrp_pkg;

    localparam int CMD_W       = 2;
    localparam int ACK_IDX_W   = 11;
    localparam int WINDOW_W    = 16;
    localparam int COUNT_W     = 11;
    localparam int SEND_IDX_W  = 10;
    localparam int TIME_W      = 32;
    localparam int MISS_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd16;
    localparam logic [TIME_W-1:0]   TIME_MAX     = 32'hFFFF_FFFF;
    localparam logic [MISS_W-1:0]   MISS_LIMIT   = 3'd5;
    localparam int                  DUE_MARGIN   = 4;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [ACK_IDX_W-1:0] ack_index;
    } t_cmd_item;

    typedef struct packed {
        logic                  send_valid;
        logic [SEND_IDX_W-1:0] send_index;
        logic                  all_done;
        logic [TIME_W-1:0]     time_now;
    } t_result;

    // One packet-table entry: acked flag and last send time.
    typedef struct packed {
        logic              acked;
        logic [TIME_W-1:0] stamp;
    } t_entry;

endpackage

/* hw/rtl/srrp_table.sv */
// Packet table of the retransmit picker: one write port, one registered read port.
// Depends on srrp_pkg for the entry type.
module srrp_table
    import srrp_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/selective_repeat_retransmit_picker_top.sv */
// Top level of the selective-repeat retransmit picker: sequencer, scan unit, config.
// Depends on srrp_pkg, srrp_table and selective_repeat_retransmit_picker_top_assert.svh.
//
// Channel   Direction  Handshake                     Payload
// command   in         start, busy                   i_cmd (t_cmd_item)
// result    out        o_res_strobe (one cycle)      o_result (t_result)
// config    in         i_cfg_valid, o_cfg_ready      i_cfg_index, i_cfg_data
//
// After reset the table is cleared in a pass over all MAX_PACKETS entries with busy high.
// A start transaction rewrites the whole table and then gives its result.
// An ack or timeout scans from the scan start toward the count, stopping at the first due entry,
// one entry per cycle through the table read port and one shared due comparator.
// busy stays high until the result strobe; results cannot be stalled by the receiver.
`include "selective_repeat_retransmit_picker_top_assert.svh"

module selective_repeat_retransmit_picker_top
    import srrp_pkg::*;
#(
    parameter int MAX_PACKETS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd_item             i_cmd,
    output logic                  o_res_strobe,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_PACKETS);
    localparam int CW = $clog2(MAX_PACKETS + 1);
    localparam int AW = (CW > ACK_IDX_W) ? CW : ACK_IDX_W;
    localparam int FW = (CW > WINDOW_W) ? CW : WINDOW_W;
    localparam int PW = (IW > SEND_IDX_W) ? IW : SEND_IDX_W;
    localparam int DW = TIME_W + 2;
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_PACKETS - 1);

    localparam logic [1:0] S_FILL = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        return (v == TIME_MAX) ? v : v + TIME_W'(1);
    endfunction

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_ridx, n_ridx;
    logic [IW-1:0]       r_cidx, n_cidx;
    logic                r_chk, n_chk;
    logic                r_skip, n_skip;
    logic                r_seen, n_seen;
    logic                r_found, n_found;
    logic [IW-1:0]       r_pick, n_pick;
    logic [CW-1:0]       r_first, n_first;
    logic                r_report, n_report;
    logic [CW-1:0]       r_scan, n_scan;
    logic [TIME_W-1:0]   r_clock, n_clock;
    logic [MISS_W-1:0]   r_miss, n_miss;
    logic [WINDOW_W-1:0] r_window, n_window;
    logic [COUNT_W-1:0]  r_pkt_count, n_pkt_count;
    logic                r_strobe, n_strobe;
    t_result             r_result, n_result;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    t_entry              mem_wdata;
    logic                mem_re;
    logic [IW-1:0]       mem_raddr;
    t_entry              rd;

    logic                accept;
    logic [AW-1:0]       ack_w;
    logic [AW-1:0]       cnt_w;
    logic [AW-1:0]       max_w;
    logic [AW-1:0]       n_eff_w;
    logic [CW-1:0]       n_eff;
    logic [FW-1:0]       win_f;
    logic [FW-1:0]       cnt_f;
    logic [DW-1:0]       due_sum;
    logic                due;
    logic                hit;
    logic                miss_wrap;
    logic [TIME_W-1:0]   clk_m;
    logic [MISS_W-1:0]   miss_base;
    logic [PW-1:0]       pick_w;

    srrp_table #(
        .DEPTH (MAX_PACKETS),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Effective count is the configured count clamped to the table depth.
    assign ack_w   = AW'(i_cmd.ack_index);
    assign cnt_w   = AW'(r_pkt_count);
    assign max_w   = AW'(MAX_PACKETS);
    assign n_eff_w = (cnt_w < max_w) ? cnt_w : max_w;
    assign n_eff   = n_eff_w[CW-1:0];
    assign win_f   = FW'(r_window);
    assign cnt_f   = FW'(n_eff);

    // Shared due comparator: clock >= send time + window + margin, without wrap.
    assign due_sum = DW'(rd.stamp) + DW'(r_window) + DW'(DUE_MARGIN);
    assign due     = DW'(r_clock) >= due_sum;
    assign hit     = r_chk && !rd.acked && due;

    assign miss_wrap = (r_miss == MISS_LIMIT);
    assign clk_m     = miss_wrap ? sat_inc(r_clock) : r_clock;
    assign miss_base = miss_wrap ? '0 : r_miss;
    assign pick_w    = PW'(r_pick);

    always_comb begin
        n_state     = r_state;
        n_ridx      = r_ridx;
        n_cidx      = r_cidx;
        n_chk       = r_chk;
        n_skip      = r_skip;
        n_seen      = r_seen;
        n_found     = r_found;
        n_pick      = r_pick;
        n_first     = r_first;
        n_report    = r_report;
        n_scan      = r_scan;
        n_clock     = r_clock;
        n_miss      = r_miss;
        n_window    = r_window;
        n_pkt_count = r_pkt_count;
        n_strobe    = 1'b0;
        n_result    = r_result;
        mem_we      = 1'b0;
        mem_waddr   = r_ridx[IW-1:0];
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_ridx[IW-1:0];

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW: n_window    = i_cfg_data;
                CFG_COUNT:  n_pkt_count = i_cfg_data[COUNT_W-1:0];
                default:    ;
            endcase
        end

        unique case (r_state)
            S_FILL: begin
                mem_we          = 1'b1;
                mem_wdata.acked = 1'b0;
                mem_wdata.stamp = (r_ridx < r_first) ? TIME_W'(r_ridx) : '0;
                n_ridx          = r_ridx + CW'(1);
                if (r_ridx == LAST_IDX) begin
                    n_state = S_IDLE;
                    if (r_report) begin
                        n_clock             = TIME_W'(r_first);
                        n_scan              = '0;
                        n_miss              = '0;
                        n_strobe            = 1'b1;
                        n_result.send_valid = 1'b0;
                        n_result.send_index = '0;
                        n_result.all_done   = (n_eff == '0);
                        n_result.time_now   = TIME_W'(r_first);
                    end
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.command == CMD_START) begin
                        n_first  = (win_f < cnt_f) ? CW'(win_f) : n_eff;
                        n_ridx   = '0;
                        n_report = 1'b1;
                        n_state  = S_FILL;
                    end else begin
                        // Acks of in-range packets mark the entry; every ack ticks the clock.
                        if (i_cmd.command == CMD_ACK) begin
                            n_clock = sat_inc(r_clock);
                            if (ack_w < n_eff_w) begin
                                mem_we          = 1'b1;
                                mem_waddr       = ack_w[IW-1:0];
                                mem_wdata.acked = 1'b1;
                            end
                        end
                        n_ridx  = r_scan;
                        n_chk   = 1'b0;
                        n_skip  = 1'b1;
                        n_seen  = 1'b0;
                        n_found = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Evaluate the entry read last cycle while the next read is issued.
                if (r_chk) begin
                    if (rd.acked) begin
                        if (r_skip) begin
                            n_scan = CW'(r_cidx) + CW'(1);
                        end
                    end else begin
                        n_skip = 1'b0;
                        n_seen = 1'b1;
                    end
                end
                if (hit) begin
                    n_found = 1'b1;
                    n_pick  = r_cidx;
                    n_chk   = 1'b0;
                    n_state = S_DONE;
                end else if (r_ridx < n_eff) begin
                    mem_re = 1'b1;
                    n_cidx = r_ridx[IW-1:0];
                    n_chk  = 1'b1;
                    n_ridx = r_ridx + CW'(1);
                end else begin
                    n_chk   = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_clock = clk_m;
                if (r_found) begin
                    n_miss          = miss_base;
                    mem_we          = 1'b1;
                    mem_waddr       = r_pick;
                    mem_wdata.acked = 1'b0;
                    mem_wdata.stamp = clk_m;
                end else begin
                    n_miss = miss_base + MISS_W'(1);
                end
                n_strobe            = 1'b1;
                n_result.send_valid = r_found;
                n_result.send_index = r_found ? pick_w[SEND_IDX_W-1:0] : '0;
                n_result.all_done   = !r_seen;
                n_result.time_now   = clk_m;
                n_state             = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_ridx      <= '0;
            r_chk       <= 1'b0;
            r_skip      <= 1'b0;
            r_seen      <= 1'b0;
            r_found     <= 1'b0;
            r_first     <= '0;
            r_report    <= 1'b0;
            r_scan      <= '0;
            r_clock     <= '0;
            r_miss      <= '0;
            r_window    <= WINDOW_RESET;
            r_pkt_count <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ridx      <= n_ridx;
            r_chk       <= n_chk;
            r_skip      <= n_skip;
            r_seen      <= n_seen;
            r_found     <= n_found;
            r_first     <= n_first;
            r_report    <= n_report;
            r_scan      <= n_scan;
            r_clock     <= n_clock;
            r_miss      <= n_miss;
            r_window    <= n_window;
            r_pkt_count <= n_pkt_count;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cidx   <= n_cidx;
        r_pick   <= n_pick;
        r_result <= n_result;
    end

    assign o_res_strobe = r_strobe;
    assign o_result     = r_result;

    `SRRP_ASSERT_NEXT(a_accept_holds_busy, i_clk, i_rst_n, accept, busy)
    `SRRP_ASSERT_NEXT(a_done_gives_strobe, i_clk, i_rst_n, r_state == S_DONE, o_res_strobe)
    `SRRP_ASSERT_IMP(a_send_not_done, i_clk, i_rst_n, o_res_strobe && o_result.send_valid, !o_result.all_done)
    `SRRP_ASSERT_IMP(a_scan_start_monotonic, i_clk, i_rst_n, (r_state == S_SCAN) && $past(r_state == S_SCAN), r_scan >= $past(r_scan))

endmodule

/* sim/tb_selective_repeat_retransmit_picker_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for selective_repeat_retransmit_picker_top: a shadow copy of
// the packet table predicts each result, and directed and random command traffic checks it.
// Depends on srrp_pkg and the picker RTL.
module tb_selective_repeat_retransmit_picker_top;
    import srrp_pkg::*;

    localparam int NUM_ENTRIES    = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 580;
    localparam int BIG_PHASES     = 2;

    // Codes the package leaves unnamed: command 3 acts as a timeout, and
    // register indexes 2 and 3 hold nothing.
    localparam logic [CMD_W-1:0]     CMD_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    class picker_shadow;
        logic [WINDOW_W-1:0] window;
        logic [COUNT_W-1:0]  count;
        bit                  acked [NUM_ENTRIES];
        logic [TIME_W-1:0]   stamp [NUM_ENTRIES];
        int                  scan_pos;
        logic [TIME_W-1:0]   clk_now;
        logic [MISS_W-1:0]   misses;
        t_result             expected_picks [$];
        int                  errors;

        function new();
            window   = WINDOW_RESET;
            count    = '0;
            scan_pos = 0;
            clk_now  = '0;
            misses   = '0;
            errors   = 0;
            foreach (acked[i]) begin
                acked[i] = 1'b0;
                stamp[i] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_WINDOW) begin
                window = data;
            end else if (idx == CFG_COUNT) begin
                count = data[COUNT_W-1:0];
            end
        endfunction

        function void tick();
            if (clk_now != TIME_MAX) begin
                clk_now = clk_now + 1'b1;
            end
        endfunction

        function void note_command(t_cmd_item c);
            int                n;
            int                first;
            int                pick;
            bit                found;
            bit                done;
            logic [TIME_W+1:0] due;
            t_result           r;
            n     = (int'(count) > NUM_ENTRIES) ? NUM_ENTRIES : int'(count);
            found = 1'b0;
            pick  = 0;
            if (c.command == CMD_START) begin
                first = (int'(window) < n) ? int'(window) : n;
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    acked[i] = 1'b0;
                    stamp[i] = (i < first) ? TIME_W'(i) : '0;
                end
                clk_now  = TIME_W'(first);
                scan_pos = 0;
                misses   = '0;
            end else begin
                if (c.command == CMD_ACK) begin
                    if (int'(c.ack_index) < n) begin
                        acked[c.ack_index] = 1'b1;
                    end
                    tick();
                end
                while (scan_pos < n && acked[scan_pos]) begin
                    scan_pos++;
                end
                // The due test is done two bits wider so it never wraps.
                for (int i = scan_pos; i < n && !found; i++) begin
                    due = {2'b00, stamp[i]} + {18'd0, window} + 34'(DUE_MARGIN);
                    if (!acked[i] && {2'b00, clk_now} >= due) begin
                        found = 1'b1;
                        pick  = i;
                    end
                end
                // The clock advance from a run of misses lands before the restamp.
                if (misses == MISS_LIMIT) begin
                    tick();
                    misses = '0;
                end
                if (found) begin
                    stamp[pick] = clk_now;
                end else begin
                    misses = misses + 1'b1;
                end
            end
            done = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (!acked[i]) begin
                    done = 1'b0;
                end
            end
            r.send_valid = found;
            r.send_index = found ? SEND_IDX_W'(pick) : '0;
            r.all_done   = done;
            r.time_now   = clk_now;
            expected_picks.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_picks.size() == 0) begin
                $error("result with no transaction outstanding: %h", got);
                errors++;
                return;
            end
            want = expected_picks.pop_front();
            if (got.send_valid !== want.send_valid) begin
                $error("send_valid: expected %0d, got %0d", want.send_valid, got.send_valid);
                errors++;
            end
            if (got.send_index !== want.send_index) begin
                $error("send_index: expected %0d, got %0d", want.send_index, got.send_index);
                errors++;
            end
            if (got.all_done !== want.all_done) begin
                $error("all_done: expected %0d, got %0d", want.all_done, got.all_done);
                errors++;
            end
            if (got.time_now !== want.time_now) begin
                $error("time_now: expected %0d, got %0d", want.time_now, got.time_now);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_cmd_item             i_cmd       = '0;
    logic                  o_res_strobe;
    t_result               o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    picker_shadow shadow;
    int           quiet_cycles = 0;
    int           perm [$];

    selective_repeat_retransmit_picker_top #(
        .MAX_PACKETS(NUM_ENTRIES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_strobe(o_res_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe === 1'b1) begin
            shadow.check_result(o_result);
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_res_strobe === 1'b1
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int next_gap(bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // start stays high across back-to-back transactions; send_item drops it only for a gap.
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [ACK_IDX_W-1:0] idx, int gap);
        t_cmd_item item;
        item.command   = cmd;
        item.ack_index = idx;
        start <= 1'b1;
        i_cmd <= item;
        do @(posedge i_clk); while (busy !== 1'b0);
        shadow.note_command(item);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (shadow.expected_picks.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        shadow.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic shuffle_acks(int n);
        int j;
        int t;
        perm.delete();
        for (int i = 0; i < n; i++) begin
            perm.push_back(i);
        end
        for (int i = n - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
    endtask

    initial begin
        int                   n;
        int                   win;
        int                   r;
        int                   phase_len;
        int                   big_left;
        int                   sent_random;
        bit                   calm;
        bit                   restart;
        logic [CMD_W-1:0]     cmd;
        logic [ACK_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] count_word;

        shadow = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty transfer straight out of reset: everything counts as done.
        send_item(CMD_TIMEOUT, 11'd0, 1);
        send_item(CMD_ACK, 11'd0, 0);
        send_item(CMD_SPARE, 11'h7FF, 2);
        wait_drained();

        // Zero window: misses push the clock until packets fall due.
        cfg_write(CFG_WINDOW, 16'd0);
        cfg_write(CFG_COUNT, 16'd4);
        send_item(CMD_START, 11'h555, 0);
        repeat (6) send_item(CMD_TIMEOUT, 11'h2AA, 0);
        send_item(CMD_ACK, 11'd5, 1);
        send_item(CMD_ACK, 11'h7FF, 0);
        for (int i = 0; i < 4; i++) begin
            send_item(CMD_ACK, 11'(i), 0);
        end
        send_item(CMD_TIMEOUT, 11'd0, 3);
        wait_drained();

        // Widest window over the full table.
        cfg_write(CFG_WINDOW, 16'hFFFF);
        cfg_write(CFG_COUNT, 16'd1024);
        send_item(CMD_START, 11'd0, 0);
        send_item(CMD_ACK, 11'd1023, 0);
        send_item(CMD_ACK, 11'd1024, 0);
        send_item(CMD_TIMEOUT, 11'd0, 1);
        wait_drained();

        // Unused register slots, and a count beyond the table that gets clamped.
        cfg_write(CFG_SPARE_A, 16'hFFFF);
        cfg_write(CFG_SPARE_B, 16'hA5A5);
        cfg_write(CFG_COUNT, 16'hFFFF);
        cfg_write(CFG_WINDOW, 16'd3);
        send_item(CMD_START, 11'h7FF, 0);
        send_item(CMD_ACK, 11'd1030, 0);
        send_item(CMD_TIMEOUT, 11'h400, 0);
        wait_drained();

        n           = 0;
        big_left    = BIG_PHASES;
        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            wait_drained();
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    win = 0;
                end
                1: begin
                    win = 65535;
                end
                2: begin
                    win = $urandom_range(0, 65535);
                end
                3: begin
                    win = $urandom_range(13, 80);
                end
                default: begin
                    win = $urandom_range(1, 12);
                end
            endcase
            // Occasionally only the window changes and the transfer carries on.
            restart = ($urandom_range(0, 6) != 0);
            if (restart) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    n = 0;
                end else if (r < 8 && big_left > 0) begin
                    n = NUM_ENTRIES;
                    big_left--;
                end else if (r < 14) begin
                    n = $urandom_range(41, 200);
                end else begin
                    n = $urandom_range(1, 40);
                end
                if (n == NUM_ENTRIES && $urandom_range(0, 1) == 1) begin
                    count_word = 16'($urandom_range(1025, 2047));
                end else begin
                    count_word = 16'(n);
                end
                // Bits above the count field are dropped by the register.
                if ($urandom_range(0, 4) == 0) begin
                    count_word[CFG_DATA_W-1:COUNT_W] = 5'($urandom);
                end
                if ($urandom_range(0, 1) == 1) begin
                    cfg_write(CFG_COUNT, count_word);
                    cfg_write(CFG_WINDOW, 16'(win));
                end else begin
                    cfg_write(CFG_WINDOW, 16'(win));
                    cfg_write(CFG_COUNT, count_word);
                end
                send_item(CMD_START, 11'($urandom), next_gap(calm));
                shuffle_acks(n);
            end else begin
                cfg_write(CFG_WINDOW, 16'(win));
            end

            phase_len = (n == NUM_ENTRIES) ? 12 : $urandom_range(n + 4, 2 * n + 12);
            for (int k = 0; k < phase_len && sent_random < RANDOM_ITEMS; k++) begin
                r   = $urandom_range(0, 99);
                idx = 11'($urandom);
                if (r < 55 && perm.size() > 0) begin
                    cmd = CMD_ACK;
                    idx = 11'(perm.pop_front());
                end else if (r < 80) begin
                    cmd = CMD_TIMEOUT;
                end else if (r < 88) begin
                    cmd = CMD_ACK;
                end else if (r < 92) begin
                    cmd = CMD_SPARE;
                end else if (r < 95) begin
                    cmd = CMD_START;
                    shuffle_acks(n);
                end else begin
                    cmd = CMD_ACK;
                    idx = (n > 0) ? 11'($urandom_range(0, n - 1)) : 11'd0;
                end
                send_item(cmd, idx, next_gap(calm));
                sent_random++;
                if ($urandom_range(0, 49) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.expected_picks.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
